/* rtl/json_string_escaper_macros.svh */
// Assertion macros for the JSON string escaper
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// checked only out of reset
`define JSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jse: check failed");

// checked in reset too
`define JSE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("jse: reset check failed");

`endif

/* rtl/jse_pkg.sv */
// Types, character codes and hex digit function shared by the JSON string escaper
package jse_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChBel    = 8'h07;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChHigh   = 8'h80;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChThree  = 8'h33;
  localparam logic [7:0] ChUpperC = 8'h43;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;

  typedef enum logic [1:0] {
    ClsDrop = 2'd0,
    ClsPass = 2'd1,
    ClsEsc  = 2'd2,
    ClsUni  = 2'd3
  } jse_cls_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_string;
    logic       end_of_string;
    logic       empty_string;
  } jse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } jse_out_t;

  // one classified input beat
  typedef struct packed {
    jse_cls_e   cls;
    logic       first;
    logic       last;
    logic [7:0] hi;
    logic [7:0] lo;
  } jse_ent_t;

  typedef struct packed {
    logic     valid;
    jse_ent_t ent;
  } jse_head_t;

  function automatic logic [7:0] jse_hex(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = ChZero + {4'd0, nib};
    end else begin
      r = ChLowA + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

endpackage

/* rtl/jse_front.sv */
// Front end: classifies an input beat into an escape class and its characters
module jse_front (
  input  jse_pkg::jse_in_t  in_i,
  output jse_pkg::jse_ent_t ent_o
);

  logic [7:0] c;

  assign c = in_i.in_byte;

  always_comb begin
    ent_o.cls   = jse_pkg::ClsPass;
    ent_o.first = in_i.start_of_string;
    ent_o.last  = in_i.end_of_string;
    ent_o.hi    = jse_pkg::jse_hex(c[7:4]);
    ent_o.lo    = c;
    if (in_i.empty_string) begin
      ent_o.cls   = jse_pkg::ClsDrop;
      ent_o.first = 1'b1;
      ent_o.last  = 1'b1;
    end else begin
      unique case (c) inside
        jse_pkg::ChBslash, jse_pkg::ChQuote: ent_o.cls = jse_pkg::ClsEsc;
        jse_pkg::ChNl: begin
          ent_o.cls = jse_pkg::ClsEsc;
          ent_o.lo  = jse_pkg::ChLowN;
        end
        jse_pkg::ChCr: begin
          ent_o.cls = jse_pkg::ClsEsc;
          ent_o.lo  = jse_pkg::ChLowR;
        end
        jse_pkg::ChTab: begin
          ent_o.cls = jse_pkg::ClsEsc;
          ent_o.lo  = jse_pkg::ChLowT;
        end
        jse_pkg::ChBs: begin
          ent_o.cls = jse_pkg::ClsEsc;
          ent_o.lo  = jse_pkg::ChLowB;
        end
        jse_pkg::ChFf: begin
          ent_o.cls = jse_pkg::ClsEsc;
          ent_o.lo  = jse_pkg::ChLowF;
        end
        jse_pkg::ChLt: begin
          ent_o.cls = jse_pkg::ClsUni;
          ent_o.hi  = jse_pkg::ChThree;
          ent_o.lo  = jse_pkg::ChUpperC;
        end
        jse_pkg::ChVt, jse_pkg::ChBel: ent_o.cls = jse_pkg::ClsDrop;
        default: begin
          if (c < jse_pkg::ChSpace || c == (jse_pkg::ChTilde + 8'd1)) begin
            ent_o.cls = jse_pkg::ClsUni;
            ent_o.lo  = jse_pkg::jse_hex(c[3:0]);
          end
        end
      endcase
    end
  end

endmodule

/* rtl/jse_queue.sv */
// Short queue of classified beats between front and back end
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  jse_pkg::jse_ent_t  ent_i,
  output logic               full_o,
  output jse_pkg::jse_head_t head_o,
  input  logic               rd_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jse_pkg::jse_ent_t ent_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign do_wr       = wr_i && !full_o;
  assign do_rd       = rd_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.ent  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      ent_q[wr_ptr_q] <= ent_i;
    end
  end

endmodule

/* rtl/jse_back.sv */
// Back end: expands the head beat into output bytes into an output register
module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jse_pkg::jse_head_t head_i,
  output logic               rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output jse_pkg::jse_out_t  out_o
);

  jse_pkg::jse_ent_t ent;
  logic [2:0]        idx_q, idx_d;
  logic [2:0]        blen, j;
  logic [3:0]        n;
  logic [7:0]        body, obyte;
  logic              olast, adv, load;
  logic              ovalid_q, ovalid_d;
  jse_pkg::jse_out_t out_q;

  assign ent = head_i.ent;

  always_comb begin
    unique case (ent.cls)
      jse_pkg::ClsPass: blen = 3'd1;
      jse_pkg::ClsEsc:  blen = 3'd2;
      jse_pkg::ClsUni:  blen = 3'd6;
      default:          blen = 3'd0;
    endcase
  end

  assign n = {3'd0, ent.first} + {1'b0, blen} + {3'd0, ent.last};
  assign j = idx_q - {2'd0, ent.first};

  always_comb begin
    unique case (ent.cls)
      jse_pkg::ClsPass: body = ent.lo;
      jse_pkg::ClsEsc:  body = (j == 3'd0) ? jse_pkg::ChBslash : ent.lo;
      jse_pkg::ClsUni: begin
        unique case (j)
          3'd0:    body = jse_pkg::ChBslash;
          3'd1:    body = jse_pkg::ChLowU;
          3'd2:    body = jse_pkg::ChZero;
          3'd3:    body = jse_pkg::ChZero;
          3'd4:    body = ent.hi;
          default: body = ent.lo;
        endcase
      end
      default: body = jse_pkg::ChQuote;
    endcase
  end

  always_comb begin
    if (ent.first && idx_q == 3'd0) begin
      obyte = jse_pkg::ChQuote;
    end else if (j < blen) begin
      obyte = body;
    end else begin
      obyte = jse_pkg::ChQuote;
    end
  end

  assign olast = ({1'b0, idx_q} == n - 4'd1);

  // a beat with nothing to emit retires without touching the output register
  assign adv  = head_i.valid && (n == 4'd0 || !ovalid_q || pop_i);
  assign load = adv && (n != 4'd0);
  assign rd_o = adv && (n == 4'd0 || olast);

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (pop_i && ovalid_q) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      ovalid_d = 1'b1;
      idx_d    = olast ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= obyte;
      out_q.out_last <= olast;
    end
  end

  assign empty_o = !ovalid_q;
  assign out_o   = out_q;

endmodule

/* rtl/json_string_escaper.sv */
// Top level of the JSON string escaper: front end, beat queue, back end
//
//   channel  handshake          payload
//   input    push / full        in_i  : in_byte, start_of_string, end_of_string, empty_string
//   result   empty / pop        out_o : out_byte, out_last
//
// One input beat per cycle is taken while the queue has room; the back end
// emits one output byte per cycle while pop stays high, so a beat yields
// 0..8 output bytes (quotes plus escape length), set by the back-end byte sequencer.
// A beat that yields no bytes retires without waiting for pop.
// Reset empties the queue and the output register; pop low stalls the back
// end, which fills the queue and then raises full.
module json_string_escaper #(
  parameter int unsigned Depth = jse_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  jse_pkg::jse_in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output jse_pkg::jse_out_t out_o
);

  jse_pkg::jse_ent_t  ent;
  jse_pkg::jse_head_t head;
  logic               rd;

  jse_front u_front (
    .in_i  (in_i),
    .ent_o (ent)
  );

  jse_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .ent_i  (ent),
    .full_o (full),
    .head_o (head),
    .rd_i   (rd)
  );

  jse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .rd_o    (rd),
    .empty_o (empty),
    .pop_i   (pop),
    .out_o   (out_o)
  );

endmodule

/* rtl/jse_checker.sv */
// Port-level checks for the JSON string escaper, bound to the top level
`include "json_string_escaper_macros.svh"

module jse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input jse_pkg::jse_out_t out_o
);

  `JSE_ASSERT_RST(a_reset_clear, !rst_ni |=> (empty && !full))
  `JSE_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(out_o)))
  `JSE_ASSERT(a_out_known, !empty |-> !$isunknown(out_o))

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);
